[rtl/core/tpsb_pkg.sv]
`default_nettype none

package tpsb_pkg;

    // Sequence limits and number formats
    localparam int          DATA_W      = 32;
    localparam int          COUNT_W     = 16;
    localparam int          CFG_IDX_W   = 2;
    localparam int          NUM_RES     = 4;
    localparam int          RES_CNT_W   = 3;
    localparam int          RES_IDX_W   = 2;
    localparam logic [COUNT_W-1:0] MAX_SYMBOLS = 16'd1024;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_LEAD  = 2'd1;

    // Result queue selector
    typedef enum logic {
        TGT_COMPARE = 1'b0,
        TGT_ALARM   = 1'b1
    } target_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_COUNT = 2'd2
    } status_t;

    // One input word
    typedef struct packed {
        logic [DATA_W-1:0] delta;
        logic              first_item;
        logic              last_item;
    } item_t;

    // One result word
    typedef struct packed {
        target_t           target;
        logic [DATA_W-1:0] word;
        status_t           status;
        logic              last_of_run;
    } res_t;

    // All results caused by one input word
    typedef struct packed {
        res_t [NUM_RES-1:0]   res;
        logic [RES_CNT_W-1:0] count;
    } bundle_t;

endpackage

`default_nettype wire

[rtl/core/tpsb_eval.sv]
`default_nettype none

module tpsb_eval
    import tpsb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire item_t             item,
    input  wire logic [DATA_W-1:0] pulse_width,
    input  wire logic [DATA_W-1:0] alarm_lead,
    output bundle_t                bundle
);

    logic [DATA_W-1:0]  compare_total_reg, compare_total_next;
    logic [DATA_W-1:0]  alarm_total_reg, alarm_total_next;
    logic [COUNT_W-1:0] symbol_counter_reg, symbol_counter_next;
    logic               fault_reg, fault_next;

    logic [DATA_W+2:0]  scaled;
    logic               scaled_ovf;
    logic [DATA_W:0]    abs_cmp;
    logic [DATA_W:0]    alarm_later;
    logic [DATA_W-1:0]  alarm_first;
    logic [DATA_W-1:0]  alarm;
    logic [DATA_W:0]    fin;
    logic [DATA_W-1:0]  cmp_word;
    logic               ok;
    status_t            err_status;

    // Arithmetic: delta*5 as shift and add, then the totals
    always_comb
    begin
        scaled      = ({3'b000, item.delta} << 2) + {3'b000, item.delta};
        scaled_ovf  = |scaled[DATA_W+2:DATA_W];
        abs_cmp     = {1'b0, compare_total_reg} + {1'b0, scaled[DATA_W-1:0]};
        alarm_later = {1'b0, alarm_total_reg} + {1'b0, item.delta};
        alarm_first = item.delta - alarm_lead;
        alarm       = item.first_item ? alarm_first : alarm_later[DATA_W-1:0];
        fin         = {1'b0, alarm} + {1'b0, alarm_lead};
        cmp_word    = item.first_item ? scaled[DATA_W-1:0]
                                      : scaled[DATA_W-1:0] - pulse_width;
    end

    // Checks, result bundle and state update
    always_comb
    begin
        ok         = 1'b1;
        err_status = ST_RANGE;

        if (item.first_item)
        begin
            if (item.delta == '0 || scaled_ovf)
                ok = 1'b0;
            else if (item.delta <= alarm_lead)
                ok = 1'b0;
            else if (item.last_item && fin[DATA_W])
                ok = 1'b0;
        end
        else
        begin
            if (symbol_counter_reg >= MAX_SYMBOLS)
            begin
                ok         = 1'b0;
                err_status = ST_COUNT;
            end
            else if (item.delta == '0 || scaled_ovf)
                ok = 1'b0;
            else if (abs_cmp[DATA_W])
                ok = 1'b0;
            else if (scaled[DATA_W-1:0] <= pulse_width)
                ok = 1'b0;
            else if (alarm_later[DATA_W])
                ok = 1'b0;
            else if (item.last_item && fin[DATA_W])
                ok = 1'b0;
        end

        bundle = '0;
        if (!ok)
        begin
            bundle.res[0] = '{TGT_COMPARE, '0, err_status, 1'b1};
            bundle.count  = RES_CNT_W'(1);
        end
        else
        begin
            bundle.res[0] = '{TGT_COMPARE, cmp_word, ST_OK, 1'b0};
            bundle.res[1] = '{TGT_COMPARE, pulse_width, ST_OK, 1'b0};
            bundle.res[2] = '{TGT_ALARM, alarm, ST_OK, ~item.last_item};
            bundle.res[3] = '{TGT_ALARM, fin[DATA_W-1:0], ST_OK, 1'b1};
            bundle.count  = item.last_item ? RES_CNT_W'(4) : RES_CNT_W'(3);
        end
        // latched fault silences later words
        if (!item.first_item && fault_reg)
            bundle.count = '0;

        compare_total_next  = compare_total_reg;
        alarm_total_next    = alarm_total_reg;
        symbol_counter_next = symbol_counter_reg;
        fault_next          = fault_reg;
        if (take)
        begin
            if (item.first_item)
            begin
                compare_total_next  = '0;
                alarm_total_next    = '0;
                symbol_counter_next = '0;
                fault_next          = 1'b0;
            end
            if (item.first_item || !fault_reg)
            begin
                if (!ok)
                    fault_next = 1'b1;
                else
                begin
                    compare_total_next  = item.first_item ? scaled[DATA_W-1:0]
                                                          : abs_cmp[DATA_W-1:0];
                    alarm_total_next    = alarm;
                    symbol_counter_next = (item.first_item ? '0 : symbol_counter_reg)
                                          + COUNT_W'(1);
                end
            end
        end
    end

    // Sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_total_reg  <= '0;
            alarm_total_reg    <= '0;
            symbol_counter_reg <= '0;
            fault_reg          <= 1'b0;
        end
        else
        begin
            compare_total_reg  <= compare_total_next;
            alarm_total_reg    <= alarm_total_next;
            symbol_counter_reg <= symbol_counter_next;
            fault_reg          <= fault_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/tpsb_serializer.sv]
`default_nettype none

module tpsb_serializer
    import tpsb_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire bundle_t bundle,
    output logic         free,
    output logic         out_valid,
    input  wire logic    out_stall,
    output res_t         res
);

    bundle_t              bundle_reg, bundle_next;
    logic [RES_IDX_W-1:0] idx_reg, idx_next;
    logic                 busy_reg, busy_next;
    logic                 fire;
    logic                 finishing;

    // Word handshake and end of bundle
    always_comb
    begin
        fire      = busy_reg && !out_stall;
        finishing = fire && (({1'b0, idx_reg} + RES_CNT_W'(1)) == bundle_reg.count);
        free      = !busy_reg || finishing;
        out_valid = busy_reg;
        res       = bundle_reg.res[idx_reg];
    end

    // Next bundle, index and busy flag
    always_comb
    begin
        bundle_next = bundle_reg;
        idx_next    = idx_reg;
        busy_next   = busy_reg;
        if (fire)
            idx_next = idx_reg + RES_IDX_W'(1);
        if (finishing)
            busy_next = 1'b0;
        if (load)
        begin
            bundle_next = bundle;
            idx_next    = '0;
            busy_next   = (bundle.count != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        bundle_reg <= bundle_next;
    end

endmodule

`default_nettype wire

[rtl/core/timed_pulse_sequence_builder_unit.sv]
// Path: an accepted word waits in the input holding register, is evaluated combinationally, and is
// loaded into the serializer's bundle register, which drives the output. Each input word yields three
// results (four with last_item, one for an error word, none for a word dropped under a held fault),
// sent through the single result port; an input holding register takes the next word while results drain.
// Reset (rst_n, async, active low) clears the totals, symbol count, fault flag,
// configuration registers and all valid flags.
`default_nettype none

module timed_pulse_sequence_builder_unit
    import tpsb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [DATA_W-1:0]    delta,
    input  wire logic                 first_item,
    input  wire logic                 last_item,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      target,
    output logic [DATA_W-1:0]         word,
    output logic [1:0]                status,
    output logic                      last_of_run
);

    logic [DATA_W-1:0] pulse_width_reg, pulse_width_next;
    logic [DATA_W-1:0] alarm_lead_reg, alarm_lead_next;
    logic              in_valid_reg, in_valid_next;
    item_t             item_reg, item_next;
    logic              accept;
    logic              take;
    logic              ser_free;
    bundle_t           bundle;
    res_t              res;

    // Configuration decode
    always_comb
    begin
        pulse_width_next = pulse_width_reg;
        alarm_lead_next  = alarm_lead_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PULSE_WIDTH: pulse_width_next = cfg_data;
                REG_ALARM_LEAD:  alarm_lead_next  = cfg_data;
                default: ;
            endcase
        end
    end

    // Input holding register
    always_comb
    begin
        take          = in_valid_reg && ser_free;
        in_stall      = in_valid_reg && !take;
        accept        = in_valid && !in_stall;
        in_valid_next = accept ? 1'b1 : (take ? 1'b0 : in_valid_reg);
        item_next     = accept ? item_t'{delta, first_item, last_item} : item_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_width_reg <= '0;
            alarm_lead_reg  <= '0;
            in_valid_reg    <= 1'b0;
        end
        else
        begin
            pulse_width_reg <= pulse_width_next;
            alarm_lead_reg  <= alarm_lead_next;
            in_valid_reg    <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    tpsb_eval u_eval (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .item        (item_reg),
        .pulse_width (pulse_width_reg),
        .alarm_lead  (alarm_lead_reg),
        .bundle      (bundle)
    );

    tpsb_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .bundle    (bundle),
        .free      (ser_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    // Result word fields
    always_comb
    begin
        target      = res.target;
        word        = res.word;
        status      = res.status;
        last_of_run = res.last_of_run;
    end

endmodule

`default_nettype wire

[verif/tb_top.sv]
`default_nettype none

module tb_top;
    import tpsb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] LIM32       = 64'hFFFF_FFFF;
    localparam int          DRAIN_GAP   = 10;
    localparam int          HOLD_CYCLES = 150;
    localparam int          STALL_LIMIT = 3000;

    // Clock, reset and block ports
    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = REG_PULSE_WIDTH;
    logic [DATA_W-1:0]    cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [DATA_W-1:0]    delta       = '0;
    logic                 first_item  = 1'b0;
    logic                 last_item   = 1'b0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic                 target;
    logic [DATA_W-1:0]    word;
    logic [1:0]           status;
    logic                 last_of_run;

    // Words waiting to be sent and results still owed by the block
    item_t pending_words[$];
    res_t  exp_words[$];

    // Predictor state and its copy of the registers
    logic [DATA_W-1:0]  cfg_pulse_width = '0;
    logic [DATA_W-1:0]  cfg_alarm_lead  = '0;
    logic [DATA_W-1:0]  cmp_acc         = '0;
    logic [DATA_W-1:0]  alarm_acc       = '0;
    logic [COUNT_W-1:0] sym_count       = '0;
    logic               fault_hold      = 1'b0;

    int  idle_pct   = 35;
    bit  hold_go    = 1'b0;
    int  err_count  = 0;

    timed_pulse_sequence_builder_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .delta       (delta),
        .first_item  (first_item),
        .last_item   (last_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .target      (target),
        .word        (word),
        .status      (status),
        .last_of_run (last_of_run)
    );

    always #5 clk = ~clk;

    function automatic void push_result(input target_t t, input logic [DATA_W-1:0] w,
                                        input status_t s, input logic l);
        res_t r;
        r.target      = t;
        r.word        = w;
        r.status      = s;
        r.last_of_run = l;
        exp_words.push_back(r);
    endfunction

    // Expected compare/alarm words for one accepted input word
    function automatic void predict_pulse_words(input logic [DATA_W-1:0] d, input logic first,
                                                input logic last);
        logic [63:0] scaled;
        logic [63:0] abs_cmp;
        logic [63:0] alarm;
        logic [63:0] fin;
        logic [63:0] cmp_w;
        status_t     st;
        scaled  = {32'd0, d} * 64'd5;
        abs_cmp = '0;
        alarm   = '0;
        cmp_w   = '0;
        st      = ST_OK;
        if (!first && fault_hold)
            return;
        if (first)
        begin
            cmp_acc    = '0;
            alarm_acc  = '0;
            sym_count  = '0;
            fault_hold = 1'b0;
            if (scaled == 0 || scaled > LIM32 || {32'd0, d} <= {32'd0, cfg_alarm_lead})
                st = ST_RANGE;
            else
            begin
                alarm   = {32'd0, d} - {32'd0, cfg_alarm_lead};
                abs_cmp = scaled;
                cmp_w   = scaled;
            end
        end
        else if (sym_count >= MAX_SYMBOLS)
            st = ST_COUNT;
        else
        begin
            abs_cmp = {32'd0, cmp_acc} + scaled;
            alarm   = {32'd0, alarm_acc} + {32'd0, d};
            if (d == 0 || scaled > LIM32 || abs_cmp > LIM32 ||
                scaled <= {32'd0, cfg_pulse_width} || alarm > LIM32)
                st = ST_RANGE;
            else
                cmp_w = scaled - {32'd0, cfg_pulse_width};
        end
        fin = alarm + {32'd0, cfg_alarm_lead};
        if (st == ST_OK && last && fin > LIM32)
            st = ST_RANGE;
        // Any failed check: one error word, totals untouched
        if (st != ST_OK)
        begin
            fault_hold = 1'b1;
            push_result(TGT_COMPARE, '0, st, 1'b1);
            return;
        end
        cmp_acc   = abs_cmp[31:0];
        alarm_acc = alarm[31:0];
        sym_count = sym_count + 1'b1;
        push_result(TGT_COMPARE, cmp_w[31:0], ST_OK, 1'b0);
        push_result(TGT_COMPARE, cfg_pulse_width, ST_OK, 1'b0);
        push_result(TGT_ALARM, alarm[31:0], ST_OK, !last);
        if (last)
            push_result(TGT_ALARM, fin[31:0], ST_OK, 1'b1);
    endfunction

    // Input driver: takes words from the pending queue, random gaps
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        item_t nxt;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            delta      <= '0;
            first_item <= 1'b0;
            last_item  <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_pulse_words(delta, first_item, last_item);
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    nxt = pending_words.pop_front();
                    in_valid   <= 1'b1;
                    delta      <= nxt.delta;
                    first_item <= nxt.first_item;
                    last_item  <= nxt.last_item;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stall, with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        res_t exp_w;
        int   hold_left;
        bit   hold_done;
        bit   stall_nxt;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (exp_words.size() == 0)
                begin
                    $error("unexpected result word: target %0d word %h status %0d last %0d",
                           target, word, status, last_of_run);
                    err_count++;
                end
                else
                begin
                    exp_w = exp_words.pop_front();
                    if (target !== exp_w.target)
                    begin
                        $error("target: expected %0d, got %0d", exp_w.target, target);
                        err_count++;
                    end
                    if (word !== exp_w.word)
                    begin
                        $error("word: expected %h, got %h", exp_w.word, word);
                        err_count++;
                    end
                    if (status !== exp_w.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_w.status, status);
                        err_count++;
                    end
                    if (last_of_run !== exp_w.last_of_run)
                    begin
                        $error("last_of_run: expected %0d, got %0d",
                               exp_w.last_of_run, last_of_run);
                        err_count++;
                    end
                end
            end
            if (hold_go && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            else if (hold_left != 0)
                hold_left--;
            stall_nxt = (hold_left != 0) || ($urandom_range(0, 99) < idle_pct);
            out_stall <= stall_nxt;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin : watchdog_proc
        int quiet;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT)
        begin
            $display("timed_pulse_sequence_builder_unit test failed");
            $finish;
        end
    end

    task automatic write_regs(input logic [DATA_W-1:0] pw, input logic [DATA_W-1:0] lead);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PULSE_WIDTH;
        cfg_data  <= pw;
        @(posedge clk);
        cfg_index <= REG_ALARM_LEAD;
        cfg_data  <= lead;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_pulse_width = pw;
        cfg_alarm_lead  = lead;
    endtask

    // Wait until the sender has nothing left and everything owed has come back, then settle
    task automatic wait_drain();
        @(negedge clk);
        while (pending_words.size() != 0 || in_valid || exp_words.size() != 0)
            @(negedge clk);
        repeat (DRAIN_GAP) @(negedge clk);
    endtask

    task automatic queue_word(input logic [DATA_W-1:0] d, input logic first, input logic last);
        item_t it;
        it.delta      = d;
        it.first_item = first;
        it.last_item  = last;
        pending_words.push_back(it);
    endtask

    // One sequence: start, n_later spacings, mostly legal values
    task automatic queue_sequence(input int n_later);
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] min_d;
        logic [DATA_W-1:0] d;
        if ($urandom_range(0, 9) == 0)
            start = $urandom_range(32'h3000_0000, 32'h3333_3333);
        else
            start = cfg_alarm_lead + $urandom_range(1, 50000);
        queue_word(start, 1'b1, n_later == 0);
        min_d = cfg_pulse_width / 5 + 1;
        for (int i = 0; i < n_later; i++)
        begin
            if ($urandom_range(0, 14) == 0)
                d = $urandom_range(0, min_d - 1);
            else
                d = min_d + $urandom_range(0, 20000);
            queue_word(d, 1'b0, (i == n_later - 1) || ($urandom_range(0, 19) == 0));
        end
    endtask

    task automatic queue_random(input int n_items);
        int n;
        int len;
        n = 0;
        while (n < n_items)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                len = $urandom_range(0, 6);
                queue_sequence(len);
                n += len + 1;
            end
            else
            begin
                queue_word($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                n++;
            end
        end
    endtask

    // Stimulus phases
    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed corner cases
        write_regs(32'd7, 32'd3);
        queue_word(32'd10, 1'b0, 1'b0);          // spacing with no start since reset
        queue_word(32'd0, 1'b1, 1'b0);           // zero start
        queue_word(32'd5, 1'b0, 1'b0);           // ignored while fault held
        queue_word(32'd3, 1'b1, 1'b0);           // start equal to alarm lead
        queue_word(32'd4, 1'b1, 1'b0);
        queue_word(32'd0, 1'b0, 1'b0);           // zero spacing
        queue_word(32'd100, 1'b1, 1'b0);
        queue_word(32'd1, 1'b0, 1'b0);           // compare word not above pulse width
        queue_word(32'd100, 1'b1, 1'b0);
        queue_word(32'd2, 1'b0, 1'b0);
        queue_word(32'd9, 1'b0, 1'b1);           // closing alarm
        queue_word(32'd20, 1'b0, 1'b0);          // keeps going after last mark
        queue_word(32'hFFFF_FFFF, 1'b0, 1'b0);   // scaled spacing overflow
        queue_word(32'h3333_3334, 1'b1, 1'b0);   // scaled start overflow
        queue_word(32'h3333_3333, 1'b1, 1'b0);   // compare total at max
        queue_word(32'd1, 1'b0, 1'b0);           // absolute compare overflow
        queue_word(32'd50, 1'b1, 1'b1);          // start and last together
        queue_word(32'hFFFF_FFFF, 1'b1, 1'b1);
        queue_word(32'h8000_0000, 1'b0, 1'b0);
        queue_word(32'h1000_0000, 1'b1, 1'b0);
        queue_word(32'h0AAA_AAAA, 1'b0, 1'b1);
        wait_drain();

        // Zero registers, receiver holds off while the sender keeps going
        write_regs(32'd0, 32'd0);
        hold_go = 1'b1;
        queue_random(40);
        wait_drain();

        write_regs($urandom_range(1, 1000), $urandom_range(0, 1000));
        queue_random(40);
        wait_drain();

        // All-ones registers: every start fails and every spacing is dropped under the held fault
        write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_word(32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_word(32'h3333_3333, 1'b0, 1'b0);
        queue_random(13);
        wait_drain();

        write_regs($urandom_range(0, 100000), $urandom_range(0, 1000));
        queue_random(40);
        wait_drain();

        // No idling on either side
        idle_pct = 0;
        write_regs($urandom_range(0, 1000), $urandom_range(0, 1000));
        queue_random(40);
        wait_drain();
        idle_pct = 35;

        // Wide random registers
        write_regs($urandom | 32'h8000_0000, $urandom);
        queue_random(25);
        wait_drain();

        if (exp_words.size() != 0)
        begin
            $error("%0d result words never arrived", exp_words.size());
            err_count++;
        end
        if (err_count == 0)
            $display("timed_pulse_sequence_builder_unit test passed");
        else
            $display("timed_pulse_sequence_builder_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire
